// ----- src/lpe_pkg.sv -----
// Package for the serial LED pixel encoder: op codes, palette constants,
// effect factor widths and the line-bit spreading function.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package lpe_pkg;

  // Palette size; the command index is 5 bits, so at most 32 entries.
  localparam int PALETTE_ENTRIES = 32;
  localparam int PAL_IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam int CMD_W = 8;
  localparam int INDEX_W = 5;
  localparam int COLOR_W = 24;
  localparam int BYTE_W = 8;
  localparam int LINE_W = 3 * BYTE_W;
  localparam int PHASE_W = 5;
  localparam int FAST_W = 3;
  localparam int FACTOR_W = 6;
  localparam int FACTOR_SHIFT = 5;

  localparam logic [INDEX_W:0] PAL_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);
  localparam logic [FACTOR_W-1:0] FACTOR_FULL = FACTOR_W'(32);

  // Bit positions inside a pixel command.
  localparam int CMD_ON_BIT = 7;
  localparam int CMD_FADE_BIT = 6;
  localparam int CMD_FAST_BIT = 5;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_WRITE = 2'd2
  } lpe_op_t;

  typedef logic [COLOR_W-1:0] color_t;

  localparam color_t DEFAULT_PALETTE [32] = '{
    24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
    24'hff00ff, 24'h00ffff, 24'hffffff, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'hffffff
  };

  // Each colour bit b becomes the line bits 1,b,0, msb first.
  function automatic logic [LINE_W-1:0] spread_byte(input logic [BYTE_W-1:0] value);
    logic [LINE_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      acc[3*k+2] = 1'b1;
      acc[3*k+1] = value[k];
      acc[3*k]   = 1'b0;
    end
    return acc;
  endfunction

  // Scales a byte by factor/32; a factor of 32 leaves it unchanged.
  function automatic logic [BYTE_W-1:0] scale_byte(input logic [BYTE_W-1:0] value,
                                                   input logic [FACTOR_W-1:0] factor);
    logic [BYTE_W+FACTOR_W-1:0] prod;
    prod = {{FACTOR_W{1'b0}}, value} * {{BYTE_W{1'b0}}, factor};
    return prod[FACTOR_SHIFT +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

// ----- src/lpe_cmd_if.sv -----
// Input channel of the pixel encoder: valid/ready plus the command fields.
// Depends on lpe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lpe_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic [lpe_pkg::CMD_W-1:0]   pixel_cmd;
  logic [lpe_pkg::INDEX_W-1:0] palette_index;
  logic [lpe_pkg::COLOR_W-1:0] palette_color;

  modport source (output valid, output op, output pixel_cmd, output palette_index,
                  output palette_color, input ready);
  modport sink (input valid, input op, input pixel_cmd, input palette_index,
                input palette_color, output ready);
endinterface

`default_nettype wire

// ----- src/lpe_line_if.sv -----
// Output channel of the pixel encoder: valid/ready plus three line-bit words.
// Depends on lpe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lpe_line_if;
  logic                      valid;
  logic                      ready;
  logic [lpe_pkg::LINE_W-1:0] green_bits;
  logic [lpe_pkg::LINE_W-1:0] red_bits;
  logic [lpe_pkg::LINE_W-1:0] blue_bits;

  modport source (output valid, output green_bits, output red_bits, output blue_bits,
                  input ready);
  modport sink (input valid, input green_bits, input red_bits, input blue_bits,
                output ready);
endinterface

`default_nettype wire

// ----- src/led_pixel_effect_bit_encoder.sv -----
// Serial LED pixel encoder with blink and fade effects, top level.
// Depends on lpe_pkg, lpe_cmd_if and lpe_line_if.
//
// Usage: transactions on cmd carry a frame tick, a palette write or a pixel
// command. Ticks and writes update internal state and produce nothing on
// line. Each pixel command produces exactly one line transaction holding
// the three colour bytes, each expanded to 24 line bits (1,b,0 per bit).
// Pipeline: a pixel command goes through the middle register (palette read
// and factor select) and then the output register (scaling and spreading).
// Throughput: one transaction per cycle, any mix of ops, as long as line
// keeps taking results; the two pipeline registers let cmd stay ready while
// a finished result waits.
// Reset: phase and both flags clear, the palette loads its default colours,
// both pipeline stages empty and cmd is not ready while reset is high.
// Stall: when line is not ready, results hold in the output register, the
// middle stage fills, and cmd then drops ready until line moves again.
`timescale 1ns / 1ps
`default_nettype none

module led_pixel_effect_bit_encoder (
  input wire logic clk,
  input wire logic rst,
  lpe_cmd_if.sink    cmd,
  lpe_line_if.source line
);
  import lpe_pkg::*;

  logic [PHASE_W-1:0] phase_count;
  logic               slow_flag;
  logic               fast_flag;
  color_t             palette [PALETTE_ENTRIES];

  logic                mid_valid;
  color_t              mid_color;
  logic [FACTOR_W-1:0] mid_factor;

  logic              out_valid;
  logic [LINE_W-1:0] out_green;
  logic [LINE_W-1:0] out_red;
  logic [LINE_W-1:0] out_blue;

  logic mid_advance;
  logic accept;

  logic [PHASE_W-1:0]  phase_next;
  logic                rd_ok;
  logic                wr_ok;
  color_t              rd_color;
  logic [FAST_W-1:0]   fast_phase;
  logic [FACTOR_W-1:0] fade_factor;
  logic                blink_shown;
  color_t              color_next;
  logic [FACTOR_W-1:0] factor_next;

  assign mid_advance = !out_valid || line.ready;
  assign cmd.ready   = !rst && (!mid_valid || mid_advance);
  assign accept      = cmd.valid && cmd.ready;

  assign phase_next = phase_count + PHASE_W'(1);
  assign rd_ok = {1'b0, cmd.pixel_cmd[INDEX_W-1:0]} < PAL_LIMIT;
  assign wr_ok = {1'b0, cmd.palette_index} < PAL_LIMIT;
  assign rd_color = rd_ok ? palette[cmd.pixel_cmd[PAL_IDX_W-1:0]] : '0;
  assign fast_phase = phase_count[FAST_W-1:0];

  always_comb begin
    if (cmd.pixel_cmd[CMD_FAST_BIT]) begin
      if (fast_flag) begin
        fade_factor = FACTOR_FULL - {1'b0, fast_phase, 2'b00};
      end else begin
        fade_factor = {1'b0, fast_phase, 2'b00} + FACTOR_W'(4);
      end
      blink_shown = fast_flag;
    end else begin
      if (slow_flag) begin
        fade_factor = FACTOR_FULL - {1'b0, phase_count};
      end else begin
        fade_factor = {1'b0, phase_count} + FACTOR_W'(1);
      end
      blink_shown = slow_flag;
    end

    // Full brightness is a factor of 32; a hidden blink shows black.
    color_next  = rd_color;
    factor_next = FACTOR_FULL;
    if (!cmd.pixel_cmd[CMD_ON_BIT]) begin
      if (cmd.pixel_cmd[CMD_FADE_BIT]) begin
        factor_next = fade_factor;
      end else if (!blink_shown) begin
        color_next = '0;
      end
    end
  end

  // State updates and the first stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      slow_flag   <= 1'b0;
      fast_flag   <= 1'b0;
      mid_valid   <= 1'b0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        palette[i] <= DEFAULT_PALETTE[i];
      end
    end else begin
      if (mid_advance) begin
        mid_valid <= 1'b0;
      end
      if (accept) begin
        case (cmd.op)
          OP_TICK: begin
            phase_count <= phase_next;
            if (phase_next[FAST_W-1:0] == '0) begin
              fast_flag <= !fast_flag;
            end
            if (phase_next == '0) begin
              slow_flag <= !slow_flag;
            end
          end
          OP_WRITE: begin
            if (wr_ok) begin
              palette[cmd.palette_index[PAL_IDX_W-1:0]] <= cmd.palette_color;
            end
          end
          OP_PIXEL: begin
            mid_valid <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.op == OP_PIXEL) begin
      mid_color  <= color_next;
      mid_factor <= factor_next;
    end
  end

  // Second stage: scale each byte and spread it into line bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_advance) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_advance && mid_valid) begin
      out_green <= spread_byte(scale_byte(mid_color[23:16], mid_factor));
      out_red   <= spread_byte(scale_byte(mid_color[15:8], mid_factor));
      out_blue  <= spread_byte(scale_byte(mid_color[7:0], mid_factor));
    end
  end

  assign line.valid      = out_valid;
  assign line.green_bits = out_green;
  assign line.red_bits   = out_red;
  assign line.blue_bits  = out_blue;

endmodule

`default_nettype wire
